[design/tea_key_message_decrypt_macros.svh]
// ----------------------------------------------------------------------------
// tea key message decrypt assertion macros
// shared concurrent assertion helpers, clocked on clk_i, off during reset
// ----------------------------------------------------------------------------
`ifndef TEA_KEY_MESSAGE_DECRYPT_MACROS_SVH
`define TEA_KEY_MESSAGE_DECRYPT_MACROS_SVH

// same-cycle implication
`define TKD_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TKD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/tkd_pkg.sv]
// ----------------------------------------------------------------------------
// tkd_pkg
// constants, pipeline data type and round sum helper for the tea decryptor
// ----------------------------------------------------------------------------
`default_nettype none

package tkd_pkg;

  localparam logic [31:0] SUM_INIT  = 32'hC6EF3720;
  localparam logic [31:0] TEA_DELTA = 32'h9E3779B9;
  localparam logic [7:0]  SEED_PAD  = 8'hFF;

  localparam int unsigned ROUNDS     = 32;
  localparam int unsigned NUM_STAGES = 2 * ROUNDS;

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] KEY_W0 = 2'd0;
  localparam logic [CFG_IDX_W-1:0] KEY_W1 = 2'd1;
  localparam logic [CFG_IDX_W-1:0] KEY_W2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] KEY_W3 = 2'd3;

  localparam logic CMD_HANDSHAKE  = 1'b0;
  localparam logic CMD_ACTIVATION = 1'b1;

  // p/q is the word pair of one block, swapped after each half round
  typedef struct packed {
    logic        cmd;
    logic [63:0] c1;
    logic [55:0] seed;
    logic [31:0] a_p;
    logic [31:0] a_q;
    logic [31:0] b_p;
    logic [31:0] b_q;
  } tkd_data_t;

  // round sum used by half round stage s
  function automatic logic [31:0] stage_sum(input int unsigned s);
    stage_sum = SUM_INIT - (TEA_DELTA * 32'(s >> 1));
  endfunction

endpackage

`default_nettype wire

[design/tea_key_message_decrypt.sv]
// path: request acceptance reaches out_valid_o through 64 half round stages plus
//   the output register, and a result stalled under out_stall_i stays held there
// throughput: one request per cycle; the whole stage chain advances together and
//   freezes only while a result is held under out_stall_i
// reset: rst_ni clears the key words to zero and every stage valid bit
// ----------------------------------------------------------------------------
// tea_key_message_decrypt
// 32 round tea decryption of two blocks in a 64 stage pipeline, with seed
// unmasking and field extraction for handshake and activation messages
// ----------------------------------------------------------------------------
`default_nettype none

module tea_key_message_decrypt (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_we_i,
  input  wire logic [tkd_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [31:0]                  cfg_data_i,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         cmd_i,
  input  wire logic [63:0]                  cipher_first_i,
  input  wire logic [63:0]                  cipher_second_i,
  input  wire logic [55:0]                  seed_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [7:0]                        deactivate_code_o,
  output logic [31:0]                       gps_id_o,
  output logic [15:0]                       derate_speed_o,
  output logic [63:0]                       manual_key_o,
  output logic [31:0]                       out_seed_o
);

  localparam int unsigned NStg = tkd_pkg::NUM_STAGES;

  logic [31:0]        key_q [4];
  logic               advance;
  logic               stg_valid [NStg+1];
  tkd_pkg::tkd_data_t stg_data  [NStg+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= 32'd0;
      key_q[1] <= 32'd0;
      key_q[2] <= 32'd0;
      key_q[3] <= 32'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tkd_pkg::KEY_W0: key_q[0] <= cfg_data_i;
        tkd_pkg::KEY_W1: key_q[1] <= cfg_data_i;
        tkd_pkg::KEY_W2: key_q[2] <= cfg_data_i;
        tkd_pkg::KEY_W3: key_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign advance    = !(out_valid_o && out_stall_i);
  assign in_stall_o = !advance;

  always_comb begin
    stg_valid[0]     = in_valid_i;
    stg_data[0].cmd  = cmd_i;
    stg_data[0].c1   = cipher_first_i;
    stg_data[0].seed = seed_i;
    stg_data[0].a_p  = cipher_first_i[63:32];
    stg_data[0].a_q  = cipher_first_i[31:0];
    stg_data[0].b_p  = cipher_second_i[63:32];
    stg_data[0].b_q  = cipher_second_i[31:0];
  end

  for (genvar s = 0; s < NStg; s++) begin : g_stage
    localparam logic [31:0] StgSum = tkd_pkg::stage_sum(s);
    localparam int unsigned KeyA   = ((s % 2) == 0) ? 2 : 0;

    tkd_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (advance),
      .valid_i (stg_valid[s]),
      .data_i  (stg_data[s]),
      .sum_i   (StgSum),
      .key_a_i (key_q[KeyA]),
      .key_b_i (key_q[KeyA+1]),
      .valid_o (stg_valid[s+1]),
      .data_o  (stg_data[s+1])
    );
  end

  tkd_format u_format (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .en_i              (advance),
    .valid_i           (stg_valid[NStg]),
    .data_i            (stg_data[NStg]),
    .out_stall_i       (out_stall_i),
    .out_valid_o       (out_valid_o),
    .deactivate_code_o (deactivate_code_o),
    .gps_id_o          (gps_id_o),
    .derate_speed_o    (derate_speed_o),
    .manual_key_o      (manual_key_o),
    .out_seed_o        (out_seed_o)
  );

endmodule

`default_nettype wire

[design/tkd_stage.sv]
// ----------------------------------------------------------------------------
// tkd_stage
// one registered tea half round applied to both blocks in parallel
// ----------------------------------------------------------------------------
`default_nettype none

module tkd_stage (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              valid_i,
  input  wire tkd_pkg::tkd_data_t data_i,
  input  wire logic [31:0]       sum_i,
  input  wire logic [31:0]       key_a_i,
  input  wire logic [31:0]       key_b_i,
  output logic                   valid_o,
  output tkd_pkg::tkd_data_t     data_o
);

  logic               valid_q;
  tkd_pkg::tkd_data_t data_d, data_q;

  function automatic logic [31:0] mix(input logic [31:0] p, input logic [31:0] s,
                                      input logic [31:0] ka, input logic [31:0] kb);
    mix = ((p << 4) + ka) ^ (p + s) ^ ((p >> 5) + kb);
  endfunction

  always_comb begin
    data_d     = data_i;
    data_d.a_p = data_i.a_q - mix(data_i.a_p, sum_i, key_a_i, key_b_i);
    data_d.a_q = data_i.a_p;
    data_d.b_p = data_i.b_q - mix(data_i.b_p, sum_i, key_a_i, key_b_i);
    data_d.b_q = data_i.b_p;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

`default_nettype wire

[design/tkd_format.sv]
// ----------------------------------------------------------------------------
// tkd_format
// unmasks the decrypted blocks, splits the result fields, output register
// ----------------------------------------------------------------------------
`default_nettype none

`include "tea_key_message_decrypt_macros.svh"

module tkd_format (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               en_i,
  input  wire logic               valid_i,
  input  wire tkd_pkg::tkd_data_t data_i,
  input  wire logic               out_stall_i,
  output logic                    out_valid_o,
  output logic [7:0]              deactivate_code_o,
  output logic [31:0]             gps_id_o,
  output logic [15:0]             derate_speed_o,
  output logic [63:0]             manual_key_o,
  output logic [31:0]             out_seed_o
);

  logic [63:0] d1, d2, p1, q;
  logic        out_valid_q;
  logic [7:0]  deact_d, deact_q;
  logic [31:0] id_d, id_q;
  logic [15:0] derate_d, derate_q;
  logic [63:0] mkey_d, mkey_q;
  logic [31:0] oseed_d, oseed_q;

  always_comb begin
    d1 = {data_i.a_p, data_i.a_q};
    d2 = {data_i.b_p, data_i.b_q};
    p1 = d1 ^ {data_i.seed, tkd_pkg::SEED_PAD};
    q  = d2 ^ data_i.c1 ^ d1;
    if (data_i.cmd == tkd_pkg::CMD_HANDSHAKE) begin
      deact_d  = p1[63:56];
      id_d     = p1[55:24];
      derate_d = {p1[15:8], p1[23:16]};
      mkey_d   = 64'd0;
      oseed_d  = 32'd0;
    end else begin
      deact_d  = 8'd0;
      id_d     = q[63:32];
      derate_d = 16'd0;
      mkey_d   = p1;
      oseed_d  = q[31:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en_i) begin
      out_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      deact_q  <= deact_d;
      id_q     <= id_d;
      derate_q <= derate_d;
      mkey_q   <= mkey_d;
      oseed_q  <= oseed_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign deactivate_code_o = deact_q;
  assign gps_id_o          = id_q;
  assign derate_speed_o    = derate_q;
  assign manual_key_o      = mkey_q;
  assign out_seed_o        = oseed_q;

  `TKD_ASSERT_NEXT(a_hs_fields, en_i && valid_i && data_i.cmd == tkd_pkg::CMD_HANDSHAKE,
                   manual_key_o == 64'd0 && out_seed_o == 32'd0,
                   "handshake result carries activation fields")
  `TKD_ASSERT_NEXT(a_act_fields, en_i && valid_i && data_i.cmd == tkd_pkg::CMD_ACTIVATION,
                   deactivate_code_o == 8'd0 && derate_speed_o == 16'd0,
                   "activation result carries handshake fields")
  `TKD_ASSERT_NEXT(a_pipe_hold, out_valid_q && out_stall_i && valid_i,
                   valid_i && $stable(data_i),
                   "pipeline tail moved while output held")
  `TKD_ASSERT_IMP(a_en_stall, out_valid_q && out_stall_i, !en_i,
                  "pipeline advanced into a held result")

endmodule

`default_nettype wire

[tb/tb_tea_key_message_decrypt.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tea_key_message_decrypt
// self-checking bench for the tea key message decryptor: a queue-fed driver
// offers handshake and activation requests, each accepted request is decoded
// by a local tea model into the expected fields, and a monitor compares every
// returned result against the oldest expectation, under several key settings
// and with random idling and stalls on both sides
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tea_key_message_decrypt;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 80;

  typedef struct {
    logic        cmd;
    logic [63:0] c1;
    logic [63:0] c2;
    logic [55:0] seed;
  } msg_t;

  typedef struct {
    logic [7:0]  deactivate_code;
    logic [31:0] gps_id;
    logic [15:0] derate_speed;
    logic [63:0] manual_key;
    logic [31:0] out_seed;
  } fields_t;

  logic                          clk_i = 1'b0;
  logic                          rst_ni = 1'b0;
  logic                          cfg_we_i = 1'b0;
  logic [tkd_pkg::CFG_IDX_W-1:0] cfg_idx_i = tkd_pkg::KEY_W0;
  logic [31:0]                   cfg_data_i = '0;
  logic                          in_valid_i = 1'b0;
  logic                          in_stall_o;
  logic                          cmd_i = tkd_pkg::CMD_HANDSHAKE;
  logic [63:0]                   cipher_first_i = '0;
  logic [63:0]                   cipher_second_i = '0;
  logic [55:0]                   seed_i = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  logic [7:0]                    deactivate_code_o;
  logic [31:0]                   gps_id_o;
  logic [15:0]                   derate_speed_o;
  logic [63:0]                   manual_key_o;
  logic [31:0]                   out_seed_o;

  logic [31:0] tea_key [4] = '{default: '0};
  msg_t        pending_msgs[$];
  fields_t     expected_fields[$];
  bit          msg_taken = 1'b0;
  int unsigned send_idle_pct = 17;
  int unsigned recv_stall_pct = 80;
  int unsigned recv_block_left = 0;
  int unsigned fail_count = 0;
  int unsigned cycle_count = 0;

  tea_key_message_decrypt DUT (.*);

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [63:0] tea_unwrap(input logic [63:0] blk);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [31:0] sum;
    int          r;
    hi  = blk[63:32];
    lo  = blk[31:0];
    sum = tkd_pkg::SUM_INIT;
    for (r = 0; r < tkd_pkg::ROUNDS; r++) begin
      lo  = lo - (((hi << 4) + tea_key[2]) ^ (hi + sum) ^ ((hi >> 5) + tea_key[3]));
      hi  = hi - (((lo << 4) + tea_key[0]) ^ (lo + sum) ^ ((lo >> 5) + tea_key[1]));
      sum = sum - tkd_pkg::TEA_DELTA;
    end
    return {hi, lo};
  endfunction

  function automatic fields_t decode_message(input msg_t m);
    fields_t     f;
    logic [63:0] d1;
    logic [63:0] p1;
    logic [63:0] q;
    f  = '{default: '0};
    d1 = tea_unwrap(m.c1);
    p1 = d1 ^ {m.seed, tkd_pkg::SEED_PAD};
    if (m.cmd == tkd_pkg::CMD_HANDSHAKE) begin
      f.deactivate_code = p1[63:56];
      f.gps_id          = p1[55:24];
      f.derate_speed    = {p1[15:8], p1[23:16]};
    end else begin
      q            = tea_unwrap(m.c2) ^ m.c1 ^ d1;
      f.gps_id     = q[63:32];
      f.manual_key = p1;
      f.out_seed   = q[31:0];
    end
    return f;
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch expected %h actual %h", $time, name, want, got);
    end
  endtask

  // request driver
  always @(negedge clk_i) begin
    bit busy;
    busy = in_valid_i && !msg_taken;
    msg_taken = 1'b0;
    if (!busy) begin
      if (rst_ni && pending_msgs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid_i      <= 1'b1;
        cmd_i           <= pending_msgs[0].cmd;
        cipher_first_i  <= pending_msgs[0].c1;
        cipher_second_i <= pending_msgs[0].c2;
        seed_i          <= pending_msgs[0].seed;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // result stall, with an optional long hold-off
  always @(negedge clk_i) begin
    if (recv_block_left > 0) begin
      out_stall_i <= 1'b1;
      recv_block_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // acceptance and result checking
  always @(posedge clk_i) begin
    msg_t    m;
    fields_t want;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      m.cmd  = cmd_i;
      m.c1   = cipher_first_i;
      m.c2   = cipher_second_i;
      m.seed = seed_i;
      expected_fields.push_back(decode_message(m));
      void'(pending_msgs.pop_front());
      msg_taken = 1'b1;
    end
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_fields.size() == 0) begin
        fail_count++;
        $display("%0t: unexpected result gps_id %h", $time, gps_id_o);
      end else begin
        want = expected_fields.pop_front();
        check_field("deactivate_code", 64'(want.deactivate_code), 64'(deactivate_code_o));
        check_field("gps_id", 64'(want.gps_id), 64'(gps_id_o));
        check_field("derate_speed", 64'(want.derate_speed), 64'(derate_speed_o));
        check_field("manual_key", want.manual_key, manual_key_o);
        check_field("out_seed", 64'(want.out_seed), 64'(out_seed_o));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL tea_key_message_decrypt");
    $finish;
  end

  task automatic write_key(input logic [tkd_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_idx_i    <= idx;
    cfg_data_i   <= value;
    tea_key[idx] = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_keys(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3);
    write_key(tkd_pkg::KEY_W0, k0);
    write_key(tkd_pkg::KEY_W1, k1);
    write_key(tkd_pkg::KEY_W2, k2);
    write_key(tkd_pkg::KEY_W3, k3);
  endtask

  task automatic add_msg(input logic cmd, input logic [63:0] c1, input logic [63:0] c2,
                         input logic [55:0] seed);
    msg_t m;
    m.cmd  = cmd;
    m.c1   = c1;
    m.c2   = c2;
    m.seed = seed;
    pending_msgs.push_back(m);
  endtask

  task automatic queue_extremes();
    add_msg(tkd_pkg::CMD_HANDSHAKE, '0, '0, '0);
    add_msg(tkd_pkg::CMD_HANDSHAKE, '1, '1, '1);
    add_msg(tkd_pkg::CMD_HANDSHAKE, '1, '0, '0);
    add_msg(tkd_pkg::CMD_HANDSHAKE, '0, '0, '1);
    // second block must not matter in handshake mode
    add_msg(tkd_pkg::CMD_HANDSHAKE, 64'h0123_4567_89AB_CDEF, 64'hDEAD_BEEF_0000_FFFF,
            56'h11_2233_4455_6677);
    add_msg(tkd_pkg::CMD_HANDSHAKE, 64'h0123_4567_89AB_CDEF, 64'h5A5A_A5A5_F0F0_0F0F,
            56'h11_2233_4455_6677);
    add_msg(tkd_pkg::CMD_ACTIVATION, '0, '0, '0);
    add_msg(tkd_pkg::CMD_ACTIVATION, '1, '1, '1);
    add_msg(tkd_pkg::CMD_ACTIVATION, '1, '0, '0);
    add_msg(tkd_pkg::CMD_ACTIVATION, '0, '1, '0);
    add_msg(tkd_pkg::CMD_ACTIVATION, '0, '0, '1);
    add_msg(tkd_pkg::CMD_ACTIVATION, {32{2'b10}}, {32{2'b01}}, {28{2'b10}});
  endtask

  task automatic queue_random(input int unsigned n);
    logic [63:0] c1;
    logic [63:0] c2;
    logic [55:0] seed;
    repeat (n) begin
      c1   = {$urandom, $urandom};
      c2   = {$urandom, $urandom};
      seed = 56'({$urandom, $urandom});
      case ($urandom_range(19))
        0: c1 = '0;
        1: c1 = '1;
        2: seed = '0;
        3: seed = '1;
        4: c2 = '1;
        default: ;
      endcase
      add_msg($urandom_range(1) ? tkd_pkg::CMD_ACTIVATION : tkd_pkg::CMD_HANDSHAKE,
              c1, c2, seed);
    end
  endtask

  task automatic wait_idle();
    while (pending_msgs.size() > 0 || expected_fields.size() > 0 || in_valid_i)
      @(negedge clk_i);
  endtask

  initial begin
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;

    // reset keys
    queue_extremes();
    wait_idle();

    set_keys('1, '1, '1, '1);
    queue_extremes();
    queue_random(190);
    wait_idle();

    set_keys($urandom, $urandom, $urandom, $urandom);
    queue_random(200);
    wait_idle();

    send_idle_pct  = 80;
    recv_stall_pct = 17;
    set_keys($urandom, $urandom, $urandom, $urandom);
    queue_random(125);
    // sender pause until everything is back
    wait_idle();
    queue_random(125);
    wait_idle();

    set_keys('0, '0, '0, '0);
    queue_random(150);
    wait_idle();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    set_keys($urandom, $urandom, $urandom, $urandom);
    // long output hold-off so the pipeline backs up into the input
    recv_block_left = 300;
    queue_random(250);
    wait_idle();

    set_keys(32'h8000_0000, 32'h0000_0001, 32'hFFFF_FFFE, 32'h7FFF_FFFF);
    queue_random(200);
    wait_idle();

    repeat (DRAIN_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && expected_fields.size() == 0) begin
      $display("PASS tea_key_message_decrypt");
    end else begin
      $display("FAIL tea_key_message_decrypt");
    end
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
+incdir+design
design/tkd_pkg.sv
design/tkd_stage.sv
design/tkd_format.sv
design/tea_key_message_decrypt.sv
tb/tb_tea_key_message_decrypt.sv
